// ===== hw/rtl/bbgb_pkg.sv =====
// ----------------------------------------------------------------------------
// bbgb_pkg
// Shared types, codes and defaults of the banded bitplane glyph blitter.
// ----------------------------------------------------------------------------
package bbgb_pkg;

	// default geometry
	localparam int SCREEN_WIDTH_D  = 800;
	localparam int SCREEN_HEIGHT_D = 480;
	localparam int BANDS_D         = 4;
	localparam int FONT_BYTES_D    = 8192;

	// coordinate width inside the engine, font address width
	localparam int CRD_W = 14;
	localparam int FA_W  = 21;

	// command codes
	typedef enum logic [2:0] {
		FN_LOAD  = 3'd0,
		FN_CLEAR = 3'd1,
		FN_PIXEL = 3'd2,
		FN_FILL  = 3'd3,
		FN_GLYPH = 3'd4,
		FN_READ  = 3'd5
	} func_t;

	// configuration register indexes
	localparam logic [2:0] CFG_PLANE = 3'd0;
	localparam logic [2:0] CFG_BAND  = 3'd1;
	localparam logic [2:0] CFG_GW    = 3'd2;
	localparam logic [2:0] CFG_GH    = 3'd3;

	localparam logic [6:0] GW_RESET = 7'd17;
	localparam logic [6:0] GH_RESET = 7'd24;

	localparam logic [7:0] CHAR_FIRST  = 8'h20;
	localparam logic [7:0] CLEAR_BLACK = 8'hFF;
	localparam logic [7:0] CLEAR_RED   = 8'h00;
	localparam logic [7:0] MASK_MSB    = 8'h80;
	localparam logic [2:0] BIT_LAST    = 3'd7;

	typedef struct packed {
		logic       plane;
		logic [1:0] band;
		logic [6:0] gw;
		logic [6:0] gh;
	} cfg_t;

	typedef struct packed {
		func_t       func;
		logic [10:0] pos_x;
		logic [10:0] pos_y;
		logic [10:0] end_x;
		logic [10:0] end_y;
		logic [7:0]  char_code;
		logic [1:0]  ink;
		logic [13:0] byte_addr;
		logic [7:0]  byte_data;
	} cmd_t;

endpackage

// ===== hw/rtl/bbgb_if.sv =====
// ----------------------------------------------------------------------------
// bbgb interfaces
// Valid/ready channels: command input, internal command queue, read result.
// ----------------------------------------------------------------------------
interface bbgb_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [10:0] pos_x;
	logic [10:0] pos_y;
	logic [10:0] end_x;
	logic [10:0] end_y;
	logic [7:0]  char_code;
	logic [1:0]  ink;
	logic [13:0] byte_addr;
	logic [7:0]  byte_data;

	modport source(output valid, func, pos_x, pos_y, end_x, end_y, char_code, ink,
		byte_addr, byte_data, input ready);
	modport sink(input valid, func, pos_x, pos_y, end_x, end_y, char_code, ink,
		byte_addr, byte_data, output ready);
endinterface

interface bbgb_cmd_if;
	logic           valid;
	logic           ready;
	bbgb_pkg::cmd_t cmd;

	modport source(output valid, cmd, input ready);
	modport sink(input valid, cmd, output ready);
endinterface

interface bbgb_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic [13:0] read_index;

	modport source(output valid, read_data, read_index, input ready);
	modport sink(input valid, read_data, read_index, output ready);
endinterface

// ===== hw/rtl/bbgb_front.sv =====
// ----------------------------------------------------------------------------
// bbgb_front
// Takes command words, drops those that draw nothing, queues the rest.
// ----------------------------------------------------------------------------
module bbgb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  bbgb_pkg::cfg_t cfg,
	bbgb_in_if.sink        req,
	bbgb_cmd_if.source     cmd
);
	import bbgb_pkg::*;

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       ink_ok;
	logic       push;
	logic       pop;

	// classify the incoming word
	assign ink_ok = (req.ink == {1'b0, cfg.plane});
	always_comb begin
		unique case (req.func)
			FN_LOAD, FN_CLEAR, FN_READ: keep = 1'b1;
			FN_PIXEL, FN_FILL:          keep = ink_ok;
			FN_GLYPH:                   keep = ink_ok && (req.char_code >= CHAR_FIRST);
			default:                    keep = 1'b0;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready && keep;
	assign pop       = cmd.valid && cmd.ready;
	assign cmd.valid = (cnt_q != 2'd0);
	assign cmd.cmd   = q_q[rd_ptr_q];

	// two-entry queue toward the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= '{
				func:      func_t'(req.func),
				pos_x:     req.pos_x,
				pos_y:     req.pos_y,
				end_x:     req.end_x,
				end_y:     req.end_y,
				char_code: req.char_code,
				ink:       req.ink,
				byte_addr: req.byte_addr,
				byte_data: req.byte_data
			};
		end
	end

endmodule

// ===== hw/rtl/bbgb_back.sv =====
// ----------------------------------------------------------------------------
// bbgb_back
// Drawing engine: font store, band buffer, per-pixel read-modify-write.
// ----------------------------------------------------------------------------
module bbgb_back #(
	parameter int SCREEN_WIDTH  = bbgb_pkg::SCREEN_WIDTH_D,
	parameter int SCREEN_HEIGHT = bbgb_pkg::SCREEN_HEIGHT_D,
	parameter int BANDS         = bbgb_pkg::BANDS_D,
	parameter int FONT_BYTES    = bbgb_pkg::FONT_BYTES_D
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bbgb_pkg::cfg_t cfg,
	bbgb_cmd_if.sink       cmd,
	bbgb_out_if.source     rsp
);
	import bbgb_pkg::*;

	localparam int BAND_ROWS  = SCREEN_HEIGHT / BANDS;
	localparam int BAND_BYTES = (SCREEN_WIDTH * BAND_ROWS + 7) / 8;
	localparam int BAND_AW    = $clog2(BAND_BYTES);
	localparam int FONT_AW    = $clog2(FONT_BYTES);
	localparam int BIT_W      = 23;
	localparam logic [CRD_W-1:0] START1 = CRD_W'(SCREEN_HEIGHT * 1 / BANDS);
	localparam logic [CRD_W-1:0] START2 = CRD_W'(SCREEN_HEIGHT * 2 / BANDS);
	localparam logic [CRD_W-1:0] START3 = CRD_W'(SCREEN_HEIGHT * 3 / BANDS);

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_GB1, S_GB2, S_GRD, S_GFET, S_GCHK,
		S_PCALC, S_PRD, S_PWR, S_NEXT, S_RRD, S_RDONE
	} state_t;

	state_t             state_q;
	func_t              op_q;
	logic [CRD_W-1:0]   cx_q, cy_q, x0_q, xhi_q, yhi_q;
	logic [10:0]        gx_q, gy_q;
	logic [6:0]         gc_q, gr_q;
	logic [7:0]         code_q;
	logic [14:0]        prod_q;
	logic [FA_W-1:0]    row_q, fa_q;
	logic               fzero_q;
	logic [BAND_AW-1:0] byte_q, clr_q;
	logic [7:0]         mask_q, fill_q;
	logic               hit_q, rin_q;
	logic [13:0]        ridx_q;
	logic               out_valid_q;
	logic [7:0]         out_data_q;
	logic [13:0]        out_idx_q;

	logic [7:0] band_mem [BAND_BYTES];
	logic [7:0] font_mem [FONT_BYTES];
	logic [7:0] band_rd_q, font_rd_q;

	// band geometry
	logic [CRD_W-1:0] start, band_end;
	always_comb begin
		unique case (cfg.band)
			2'd0:    start = '0;
			2'd1:    start = START1;
			2'd2:    start = START2;
			default: start = START3;
		endcase
	end
	assign band_end = start + CRD_W'(BAND_ROWS);

	// fill clipping
	logic [CRD_W-1:0] f_xhi, f_ylo, f_yhi, c_px, c_py, c_ex, c_ey;
	assign c_px  = CRD_W'(cmd.cmd.pos_x);
	assign c_py  = CRD_W'(cmd.cmd.pos_y);
	assign c_ex  = CRD_W'(cmd.cmd.end_x);
	assign c_ey  = CRD_W'(cmd.cmd.end_y);
	assign f_xhi = (c_ex > CRD_W'(SCREEN_WIDTH)) ? CRD_W'(SCREEN_WIDTH) : c_ex;
	assign f_ylo = (c_py < start) ? start : c_py;
	assign f_yhi = (c_ey > band_end) ? band_end : c_ey;

	// pixel address and bounds
	logic [CRD_W-1:0] rel;
	logic [BIT_W-1:0] bitn;
	logic             inb;
	assign rel  = cy_q - start;
	assign bitn = BIT_W'(rel[10:0]) * BIT_W'(SCREEN_WIDTH) + BIT_W'(cx_q);
	assign inb  = (cx_q < CRD_W'(SCREEN_WIDTH)) && (cy_q < CRD_W'(SCREEN_HEIGHT))
		&& (cy_q >= start) && (cy_q < band_end);

	// glyph row pitch and font address
	logic [4:0]      rbytes;
	logic [7:0]      gw_sum;
	logic [FA_W-1:0] fa;
	assign gw_sum = {1'b0, cfg.gw} + 8'd7;
	assign rbytes = gw_sum[7:3];
	assign fa     = row_q + FA_W'(gc_q[6:3]);

	// memory controls
	logic       band_we, font_we;
	logic [7:0] band_wd, mod_byte;
	assign mod_byte = cfg.plane ? (band_rd_q | mask_q) : (band_rd_q & ~mask_q);
	assign band_we  = (state_q == S_CLEAR) || ((state_q == S_PWR) && hit_q);
	assign band_wd  = (state_q == S_CLEAR) ? fill_q : mod_byte;
	assign font_we  = (state_q == S_IDLE) && cmd.valid && (cmd.cmd.func == FN_LOAD)
		&& (int'(cmd.cmd.byte_addr) < FONT_BYTES);

	always_ff @(posedge clk) begin
		if (band_we) band_mem[(state_q == S_CLEAR) ? clr_q : byte_q] <= band_wd;
		band_rd_q <= band_mem[byte_q];
	end

	always_ff @(posedge clk) begin
		if (font_we) font_mem[cmd.cmd.byte_addr[FONT_AW-1:0]] <= cmd.cmd.byte_data;
		font_rd_q <= font_mem[fa_q[FONT_AW-1:0]];
	end

	assign cmd.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = out_data_q;
	assign rsp.read_index = out_idx_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q <= cmd.cmd.func;
						unique case (cmd.cmd.func)
							FN_CLEAR: begin
								clr_q   <= '0;
								fill_q  <= cfg.plane ? CLEAR_RED : CLEAR_BLACK;
								state_q <= S_CLEAR;
							end
							FN_PIXEL: begin
								cx_q    <= c_px;
								cy_q    <= c_py;
								state_q <= S_PCALC;
							end
							FN_FILL: begin
								x0_q  <= c_px;
								xhi_q <= f_xhi;
								yhi_q <= f_yhi;
								cx_q  <= c_px;
								cy_q  <= f_ylo;
								if (f_ylo < f_yhi && c_px < f_xhi) state_q <= S_PCALC;
							end
							FN_GLYPH: begin
								gx_q   <= cmd.cmd.pos_x;
								gy_q   <= cmd.cmd.pos_y;
								gc_q   <= '0;
								gr_q   <= '0;
								code_q <= cmd.cmd.char_code - CHAR_FIRST;
								if (cfg.gw != '0 && cfg.gh != '0) state_q <= S_GB1;
							end
							FN_READ: begin
								byte_q  <= BAND_AW'(cmd.cmd.byte_addr);
								rin_q   <= int'(cmd.cmd.byte_addr) < BAND_BYTES;
								ridx_q  <= cmd.cmd.byte_addr;
								state_q <= S_RRD;
							end
							default: ;
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BAND_AW'(BAND_BYTES - 1)) state_q <= S_IDLE;
				end
				S_GB1: begin
					prod_q  <= 15'(code_q) * 15'(cfg.gh);
					state_q <= S_GB2;
				end
				S_GB2: begin
					row_q   <= FA_W'(prod_q) * FA_W'(rbytes);
					state_q <= S_GRD;
				end
				S_GRD: begin
					fa_q    <= fa;
					fzero_q <= fa >= FA_W'(FONT_BYTES);
					state_q <= S_GFET;
				end
				S_GFET: state_q <= S_GCHK;
				S_GCHK: begin
					cx_q <= CRD_W'(gx_q) + CRD_W'(gc_q);
					cy_q <= CRD_W'(gy_q) + CRD_W'(gr_q);
					if (font_rd_q[BIT_LAST - gc_q[2:0]] && !fzero_q) state_q <= S_PCALC;
					else state_q <= S_NEXT;
				end
				S_PCALC: begin
					byte_q  <= bitn[BAND_AW+2:3];
					mask_q  <= MASK_MSB >> bitn[2:0];
					hit_q   <= inb && (bitn[BIT_W-1:3] < (BIT_W - 3)'(BAND_BYTES));
					state_q <= S_PRD;
				end
				S_PRD: state_q <= S_PWR;
				S_PWR: state_q <= S_NEXT;
				S_NEXT: begin
					unique case (op_q)
						FN_FILL: begin
							if (cx_q + 1'b1 < xhi_q) begin
								cx_q    <= cx_q + 1'b1;
								state_q <= S_PCALC;
							end else if (cy_q + 1'b1 < yhi_q) begin
								cx_q    <= x0_q;
								cy_q    <= cy_q + 1'b1;
								state_q <= S_PCALC;
							end else begin
								state_q <= S_IDLE;
							end
						end
						FN_GLYPH: begin
							if ({1'b0, gc_q} + 8'd1 < {1'b0, cfg.gw}) begin
								gc_q    <= gc_q + 1'b1;
								state_q <= S_GRD;
							end else if ({1'b0, gr_q} + 8'd1 < {1'b0, cfg.gh}) begin
								gc_q    <= '0;
								gr_q    <= gr_q + 1'b1;
								row_q   <= row_q + FA_W'(rbytes);
								state_q <= S_GRD;
							end else begin
								state_q <= S_IDLE;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RRD: state_q <= S_RDONE;
				S_RDONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_data_q  <= rin_q ? band_rd_q : 8'h00;
						out_idx_q   <= ridx_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/banded_bitplane_glyph_blitter.sv =====
// ----------------------------------------------------------------------------
// banded_bitplane_glyph_blitter
// Draws pixels, rectangles and font glyphs into a one-bit band buffer.
// ----------------------------------------------------------------------------
// Commands pass the front queue, then the engine: a clear writes every band
// byte in turn, a fill reads and rewrites each clipped pixel, a glyph fetches a
// font byte for each glyph pixel and reads and rewrites each drawn pixel; each
// pixel is one read-modify-write on the single band buffer port. One command at a time.
// Reset clears control state and config (plane 0, band 0, glyph 17x24);
// band buffer is undefined until a clear, font store until written.
module banded_bitplane_glyph_blitter #(
	parameter int SCREEN_WIDTH  = bbgb_pkg::SCREEN_WIDTH_D,
	parameter int SCREEN_HEIGHT = bbgb_pkg::SCREEN_HEIGHT_D,
	parameter int BANDS         = bbgb_pkg::BANDS_D,
	parameter int FONT_BYTES    = bbgb_pkg::FONT_BYTES_D
) (
	input  logic       clk,
	input  logic       arst_n,
	bbgb_in_if.sink    req,
	bbgb_out_if.source rsp,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [6:0] cfg_data
);
	import bbgb_pkg::*;

	cfg_t cfg_q;
	bbgb_cmd_if cmd_q_if ();

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{plane: 1'b0, band: 2'd0, gw: GW_RESET, gh: GH_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PLANE: cfg_q.plane <= cfg_data[0];
				CFG_BAND:  cfg_q.band  <= cfg_data[1:0];
				CFG_GW:    cfg_q.gw    <= cfg_data;
				CFG_GH:    cfg_q.gh    <= cfg_data;
				default: ;
			endcase
		end
	end

	bbgb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.cmd    (cmd_q_if.source)
	);

	bbgb_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.BANDS         (BANDS),
		.FONT_BYTES    (FONT_BYTES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd_q_if.sink),
		.rsp    (rsp)
	);

endmodule
